// ----- hw/rtl/evad_pkg.sv -----
// Package for the energy voice activity detector.
// Holds widths, register indexes, reset values, the controller state type and
// the command and status structs shared by the controller and the datapath.
package evad_pkg;

    localparam int SAMPLE_FIELD_BITS = 16;
    localparam int SUM_BITS          = 48;
    localparam int POS_BITS          = 32;
    localparam int FILL_BITS         = 16;
    localparam int THR_BITS          = 16;
    localparam int ENERGY_BITS       = 16;
    localparam int CFG_DATA_BITS     = 32;
    localparam int CFG_INDEX_BITS    = 2;
    localparam int DIV_STEPS         = 48;
    localparam int ROOT_STEPS        = 24;
    localparam int STEP_BITS         = 6;
    localparam int ROOT_INDEX_BITS   = 5;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_ENERGY_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CHUNK_LENGTH     = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_SPEECH       = 2'd2;

    localparam logic [THR_BITS-1:0]  RESET_ENERGY_THRESHOLD = 16'd655;
    localparam logic [FILL_BITS-1:0] RESET_CHUNK_LENGTH     = 16'd1600;
    localparam logic [POS_BITS-1:0]  RESET_MIN_SPEECH       = 32'd8000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACCUM,
        ST_PRODUCT,
        ST_DECIDE,
        ST_DIVIDE,
        ST_ROOT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [THR_BITS-1:0]  energy_threshold;
        logic [FILL_BITS-1:0] chunk_length;
        logic [POS_BITS-1:0]  min_speech_samples;
    } cfg_t;

    typedef struct packed {
        logic                       load_sample;
        logic                       square;
        logic                       accumulate;
        logic                       product;
        logic                       decide;
        logic                       div_step;
        logic                       root_step;
        logic [ROOT_INDEX_BITS-1:0] root_index;
        logic                       emit;
    } cmd_t;

    typedef struct packed {
        logic chunk_end;
        logic report;
        logic out_free;
    } status_t;

endpackage

// ----- hw/rtl/evad_ctrl.sv -----
// Controller for the energy voice activity detector.
// Sequences sample, chunk-end, divide, root and emit steps; uses evad_pkg.
module evad_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  evad_pkg::status_t status,
    output evad_pkg::cmd_t    cmd
);

    evad_pkg::state_t                  state_reg, state_next;
    logic [evad_pkg::STEP_BITS-1:0]    step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= evad_pkg::ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        cmd          = '0;
        state_next   = state_reg;
        step_next    = step_reg;
        sample_stall = 1'b1;
        case (state_reg)
            evad_pkg::ST_IDLE:
            begin
                sample_stall = 1'b0;
                if (sample_valid)
                begin
                    cmd.load_sample = 1'b1;
                    state_next      = evad_pkg::ST_SQUARE;
                end
            end
            evad_pkg::ST_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = evad_pkg::ST_ACCUM;
            end
            evad_pkg::ST_ACCUM:
            begin
                cmd.accumulate = 1'b1;
                state_next     = status.chunk_end ? evad_pkg::ST_PRODUCT : evad_pkg::ST_IDLE;
            end
            evad_pkg::ST_PRODUCT:
            begin
                cmd.product = 1'b1;
                state_next  = evad_pkg::ST_DECIDE;
            end
            evad_pkg::ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                step_next  = '0;
                state_next = status.report ? evad_pkg::ST_DIVIDE : evad_pkg::ST_IDLE;
            end
            evad_pkg::ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == evad_pkg::STEP_BITS'(evad_pkg::DIV_STEPS - 1))
                begin
                    step_next  = '0;
                    state_next = evad_pkg::ST_ROOT;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            evad_pkg::ST_ROOT:
            begin
                cmd.root_step  = 1'b1;
                cmd.root_index = step_reg[evad_pkg::ROOT_INDEX_BITS-1:0];
                if (step_reg == evad_pkg::STEP_BITS'(evad_pkg::ROOT_STEPS - 1))
                begin
                    step_next  = '0;
                    state_next = evad_pkg::ST_EMIT;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            evad_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = evad_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = evad_pkg::ST_IDLE;
            end
        endcase
    end

    a_decide_after_product: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == evad_pkg::ST_DECIDE |-> $past(state_reg) == evad_pkg::ST_PRODUCT)
        else $error("decide step not preceded by product step");

    a_full_divide: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == evad_pkg::ST_ROOT && $past(state_reg) == evad_pkg::ST_DIVIDE)
        |-> $past(step_reg) == evad_pkg::STEP_BITS'(evad_pkg::DIV_STEPS - 1))
        else $error("root started before divide finished");

    a_emit_after_root: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == evad_pkg::ST_EMIT
        |-> ($past(state_reg) == evad_pkg::ST_ROOT || $past(state_reg) == evad_pkg::ST_EMIT))
        else $error("emit reached without root");

endmodule

// ----- hw/rtl/evad_dp.sv -----
// Datapath for the energy voice activity detector.
// Chunk accumulator, threshold product, divider, square root and result word;
// uses evad_pkg and is driven by evad_ctrl commands.
module evad_dp
#(
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  evad_pkg::cfg_t                             cfg,
    input  evad_pkg::cmd_t                             cmd,
    output evad_pkg::status_t                          status,
    input  logic signed [evad_pkg::SAMPLE_FIELD_BITS-1:0] sample,
    input  logic                                       final_sample,
    output logic                                       result_valid,
    input  logic                                       result_stall,
    output logic [evad_pkg::POS_BITS-1:0]              start_sample,
    output logic [evad_pkg::POS_BITS-1:0]              end_sample,
    output logic [evad_pkg::ENERGY_BITS-1:0]           closing_energy
);

    localparam int SQ_BITS = 2 * SAMPLE_BITS;
    localparam int SB      = evad_pkg::SUM_BITS;
    localparam int PB      = evad_pkg::POS_BITS;
    localparam int FB      = evad_pkg::FILL_BITS;
    localparam logic [SB-1:0] ROOT_TOP = SB'(1) << (SB - 2);

    logic [SAMPLE_BITS-1:0] raw, mag_next, mag_reg;
    logic                   final_reg;
    logic [SQ_BITS-1:0]     sq_reg;
    logic [2*evad_pkg::THR_BITS-1:0] thr_sq_reg;
    logic [SB-1:0]          prod_reg;
    logic                   span_ok_reg;

    logic [SB-1:0] sum_reg, sum_next;
    logic [FB-1:0] fill_reg, fill_next;
    logic [PB-1:0] chunk_pos_reg, chunk_pos_next;
    logic          active_reg, active_next;
    logic [PB-1:0] speech_pos_reg, speech_pos_next;

    logic [SB-1:0] quot_reg, quot_next;
    logic [FB-1:0] rem_reg, rem_next;
    logic [SB-1:0] rad_reg, rad_next;
    logic [SB-1:0] res_reg, res_next;

    logic                               result_valid_reg, result_valid_next;
    logic [PB-1:0]                      start_reg, end_reg;
    logic [evad_pkg::ENERGY_BITS-1:0]   energy_reg;

    logic [FB:0]   fill_inc;
    logic [SB:0]   sum_add;
    logic [PB:0]   pos_add;
    logic [PB-1:0] pos_sat;
    logic [PB-1:0] span;
    logic          is_speech;
    logic          report;
    logic          finish;
    logic [FB:0]   rem_shift;
    logic          div_take;
    logic [SB-1:0] rad_cur, res_cur, root_bit;
    logic [SB:0]   trial;
    logic          root_fits;
    logic [evad_pkg::ENERGY_BITS-1:0] energy_sat;

    // zero-extend or truncate the 16-bit field to the sample width
    assign raw      = SAMPLE_BITS'({{SAMPLE_BITS{1'b0}}, sample});
    assign mag_next = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;

    assign fill_inc  = {1'b0, fill_reg} + (FB + 1)'(1);
    assign sum_add   = {1'b0, sum_reg} + (SB + 1)'(sq_reg);
    assign pos_add   = {1'b0, chunk_pos_reg} + (PB + 1)'(fill_reg);
    assign pos_sat   = pos_add[PB] ? '1 : pos_add[PB-1:0];
    assign span      = chunk_pos_reg - speech_pos_reg;
    assign is_speech = sum_reg > prod_reg;
    assign report    = !is_speech && active_reg && span_ok_reg;
    assign finish    = (cmd.decide && !report) || cmd.emit;

    // restoring divide, one quotient bit per step
    assign rem_shift = {rem_reg, quot_reg[SB-1]};
    assign div_take  = rem_shift >= {1'b0, fill_reg};

    // bit-pair square root, one result bit per step
    assign rad_cur   = (cmd.root_index == '0) ? quot_reg : rad_reg;
    assign res_cur   = (cmd.root_index == '0) ? '0 : res_reg;
    assign root_bit  = ROOT_TOP >> {cmd.root_index, 1'b0};
    assign trial     = {1'b0, res_cur} + {1'b0, root_bit};
    assign root_fits = {1'b0, rad_cur} >= trial;

    assign energy_sat = (res_reg[SB-1:evad_pkg::ENERGY_BITS] != '0) ? '1
                      : res_reg[evad_pkg::ENERGY_BITS-1:0];

    assign status.chunk_end = (fill_inc >= {1'b0, cfg.chunk_length}) || final_reg;
    assign status.report    = report;
    assign status.out_free  = !result_valid_reg || !result_stall;

    always_comb
    begin
        sum_next          = sum_reg;
        fill_next         = fill_reg;
        chunk_pos_next    = chunk_pos_reg;
        active_next       = active_reg;
        speech_pos_next   = speech_pos_reg;
        quot_next         = quot_reg;
        rem_next          = rem_reg;
        rad_next          = rad_reg;
        res_next          = res_reg;
        result_valid_next = result_valid_reg && result_stall;

        if (cmd.accumulate)
        begin
            sum_next  = sum_add[SB] ? '1 : sum_add[SB-1:0];
            fill_next = fill_inc[FB-1:0];
        end

        if (cmd.decide)
        begin
            if (is_speech && !active_reg)
            begin
                active_next     = 1'b1;
                speech_pos_next = chunk_pos_reg;
            end
            else if (!is_speech && active_reg)
            begin
                active_next = 1'b0;
            end
            quot_next = sum_reg;
            rem_next  = '0;
        end

        if (cmd.div_step)
        begin
            if (div_take)
            begin
                rem_next = FB'(rem_shift - {1'b0, fill_reg});
            end
            else
            begin
                rem_next = rem_shift[FB-1:0];
            end
            quot_next = {quot_reg[SB-2:0], div_take};
        end

        if (cmd.root_step)
        begin
            if (root_fits)
            begin
                rad_next = rad_cur - trial[SB-1:0];
                res_next = (res_cur >> 1) + root_bit;
            end
            else
            begin
                rad_next = rad_cur;
                res_next = res_cur >> 1;
            end
        end

        if (cmd.emit)
        begin
            result_valid_next = 1'b1;
        end

        if (finish)
        begin
            chunk_pos_next = pos_sat;
            sum_next       = '0;
            fill_next      = '0;
            if (final_reg)
            begin
                chunk_pos_next  = '0;
                active_next     = 1'b0;
                speech_pos_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg          <= '0;
            fill_reg         <= '0;
            chunk_pos_reg    <= '0;
            active_reg       <= 1'b0;
            speech_pos_reg   <= '0;
            result_valid_reg <= 1'b0;
            final_reg        <= 1'b0;
        end
        else
        begin
            sum_reg          <= sum_next;
            fill_reg         <= fill_next;
            chunk_pos_reg    <= chunk_pos_next;
            active_reg       <= active_next;
            speech_pos_reg   <= speech_pos_next;
            result_valid_reg <= result_valid_next;
            if (cmd.load_sample)
            begin
                final_reg <= final_sample;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_sample)
        begin
            mag_reg <= mag_next;
        end
        if (cmd.square)
        begin
            sq_reg     <= mag_reg * mag_reg;
            thr_sq_reg <= cfg.energy_threshold * cfg.energy_threshold;
        end
        if (cmd.product)
        begin
            prod_reg    <= SB'(thr_sq_reg * fill_reg);
            span_ok_reg <= span >= cfg.min_speech_samples;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        rad_reg  <= rad_next;
        res_reg  <= res_next;
        if (cmd.emit)
        begin
            start_reg  <= speech_pos_reg;
            end_reg    <= chunk_pos_reg;
            energy_reg <= energy_sat;
        end
    end

    assign result_valid   = result_valid_reg;
    assign start_sample   = start_reg;
    assign end_sample     = end_reg;
    assign closing_energy = energy_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !(result_valid_reg && result_stall))
        else $error("result word overwritten while stalled");

    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && final_reg) |=> (!active_reg && fill_reg == '0 && chunk_pos_reg == '0))
        else $error("state not cleared after final chunk");

endmodule

// ----- hw/rtl/energy_voice_activity_detector_top.sv -----
// Top level of the energy voice activity detector.
// Holds the configuration registers and joins evad_ctrl and evad_dp; uses evad_pkg.
//
//   channel  | handshake                    | word
//   ---------+------------------------------+---------------------------------------
//   samples  | sample_valid / sample_stall  | sample, final_sample
//   results  | result_valid / result_stall  | start_sample, end_sample, closing_energy
//   config   | cfg_we                       | cfg_index, cfg_data
//
// A sample runs load, square and accumulate; a chunk end adds product and decide.
// A chunk end that reports then runs 48 divide steps, 24 root steps and an emit step,
// as the divider and square root give one bit per cycle.
// Reset clears all chunk and speech state at once; no clearing pass.
// The result word waits in a register; a new sample is accepted while it is stalled,
// and a following report waits in the emit step until the word is taken.
module energy_voice_activity_detector_top
#(
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          cfg_we,
    input  logic [evad_pkg::CFG_INDEX_BITS-1:0]           cfg_index,
    input  logic [evad_pkg::CFG_DATA_BITS-1:0]            cfg_data,
    input  logic                                          sample_valid,
    output logic                                          sample_stall,
    input  logic signed [evad_pkg::SAMPLE_FIELD_BITS-1:0] sample,
    input  logic                                          final_sample,
    output logic                                          result_valid,
    input  logic                                          result_stall,
    output logic [evad_pkg::POS_BITS-1:0]                 start_sample,
    output logic [evad_pkg::POS_BITS-1:0]                 end_sample,
    output logic [evad_pkg::ENERGY_BITS-1:0]              closing_energy
);

    evad_pkg::cfg_t    cfg_reg, cfg_next;
    evad_pkg::cmd_t    cmd;
    evad_pkg::status_t status;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                evad_pkg::CFG_ENERGY_THRESHOLD:
                    cfg_next.energy_threshold = cfg_data[evad_pkg::THR_BITS-1:0];
                evad_pkg::CFG_CHUNK_LENGTH:
                    cfg_next.chunk_length = cfg_data[evad_pkg::FILL_BITS-1:0];
                evad_pkg::CFG_MIN_SPEECH:
                    cfg_next.min_speech_samples = cfg_data[evad_pkg::POS_BITS-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.energy_threshold   <= evad_pkg::RESET_ENERGY_THRESHOLD;
            cfg_reg.chunk_length       <= evad_pkg::RESET_CHUNK_LENGTH;
            cfg_reg.min_speech_samples <= evad_pkg::RESET_MIN_SPEECH;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    evad_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .status       (status),
        .cmd          (cmd)
    );

    evad_dp
    #(
        .SAMPLE_BITS (SAMPLE_BITS)
    )
    u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .cmd            (cmd),
        .status         (status),
        .sample         (sample),
        .final_sample   (final_sample),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .start_sample   (start_sample),
        .end_sample     (end_sample),
        .closing_energy (closing_energy)
    );

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for energy_voice_activity_detector_top: drives PCM words, predicts speech
// segments and checks each result word in order. Depends on evad_pkg and the RTL only.
module tb_top;
    import evad_pkg::*;

    typedef struct {
        logic signed [SAMPLE_FIELD_BITS-1:0] pcm;
        logic                                last;
    } pcm_word_t;

    typedef struct packed {
        logic [POS_BITS-1:0]    seg_start;
        logic [POS_BITS-1:0]    seg_end;
        logic [ENERGY_BITS-1:0] seg_energy;
    } segment_t;

    typedef enum {CHUNK_LOUD, CHUNK_QUIET, CHUNK_NOISE} chunk_kind_t;

    localparam logic [63:0] SQ_SUM_MAX = 64'hFFFF_FFFF_FFFF;
    localparam logic [63:0] POS_MAX    = 64'hFFFF_FFFF;
    localparam int          SETTLE_CYCLES = 100;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0]           cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]            cfg_data = '0;
    logic                                sample_valid = 1'b0;
    logic                                sample_stall;
    logic signed [SAMPLE_FIELD_BITS-1:0] sample = '0;
    logic                                final_sample = 1'b0;
    logic                                result_valid;
    logic                                result_stall = 1'b0;
    logic [POS_BITS-1:0]                 start_sample;
    logic [POS_BITS-1:0]                 end_sample;
    logic [ENERGY_BITS-1:0]              closing_energy;

    energy_voice_activity_detector_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .sample_valid   (sample_valid),
        .sample_stall   (sample_stall),
        .sample         (sample),
        .final_sample   (final_sample),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .start_sample   (start_sample),
        .end_sample     (end_sample),
        .closing_energy (closing_energy)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    pcm_word_t pending_words[$];
    segment_t  expected_segments[$];
    pcm_word_t next_word;
    segment_t  got_segment;
    segment_t  want_segment;
    bit        idle_on = 1'b1;
    int        send_gap = 0;
    int        stall_left = 0;
    int        fail_count = 0;

    logic [THR_BITS-1:0]  cur_thr = RESET_ENERGY_THRESHOLD;
    logic [FILL_BITS-1:0] cur_len = RESET_CHUNK_LENGTH;
    logic [POS_BITS-1:0]  cur_min = RESET_MIN_SPEECH;

    logic [SUM_BITS-1:0]  sq_sum = '0;
    logic [FILL_BITS-1:0] fill = '0;
    logic [POS_BITS-1:0]  chunk_pos = '0;
    logic                 in_speech = 1'b0;
    logic [POS_BITS-1:0]  speech_pos = '0;

    function automatic logic [31:0] floor_root(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int b = 31; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= v)
                r = t;
        end
        return r[31:0];
    endfunction

    function automatic void track_word(input logic signed [SAMPLE_FIELD_BITS-1:0] s,
                                       input logic fin);
        logic [63:0] raw;
        logic [63:0] mag;
        logic [63:0] acc;
        logic [63:0] span;
        logic [63:0] count;
        logic [63:0] thr64;
        logic [63:0] rms;
        logic [63:0] next_pos;
        bit          loud;
        segment_t    seg;
        raw = {48'd0, s};
        mag = s[SAMPLE_FIELD_BITS-1] ? 64'd65536 - raw : raw;
        acc = {16'd0, sq_sum} + mag * mag;
        if (acc > SQ_SUM_MAX)
            acc = SQ_SUM_MAX;
        sq_sum = acc[SUM_BITS-1:0];
        fill = fill + 1'b1;
        span = (cur_len == 0) ? 64'd1 : {48'd0, cur_len};
        if ({48'd0, fill} >= span || fin)
        begin
            count = {48'd0, fill};
            thr64 = {48'd0, cur_thr};
            loud = {16'd0, sq_sum} > thr64 * thr64 * count;
            if (loud && !in_speech)
            begin
                in_speech = 1'b1;
                speech_pos = chunk_pos;
            end
            else if (!loud && in_speech)
            begin
                if (chunk_pos - speech_pos >= cur_min)
                begin
                    rms = {32'd0, floor_root({16'd0, sq_sum} / count)};
                    if (rms > 64'hFFFF)
                        rms = 64'hFFFF;
                    seg.seg_start = speech_pos;
                    seg.seg_end = chunk_pos;
                    seg.seg_energy = rms[ENERGY_BITS-1:0];
                    expected_segments.insert(expected_segments.size(), seg);
                end
                in_speech = 1'b0;
            end
            next_pos = {32'd0, chunk_pos} + count;
            if (next_pos > POS_MAX)
                next_pos = POS_MAX;
            chunk_pos = next_pos[POS_BITS-1:0];
            sq_sum = '0;
            fill = '0;
            if (fin)
            begin
                chunk_pos = '0;
                in_speech = 1'b0;
                speech_pos = '0;
            end
        end
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sample_valid && !sample_stall)
                track_word(sample, final_sample);
            if (!sample_valid || !sample_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap = send_gap - 1;
                    sample_valid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    next_word = pending_words.pop_front();
                    sample_valid <= 1'b1;
                    sample <= next_word.pcm;
                    final_sample <= next_word.last;
                    if (idle_on && $urandom_range(9, 0) == 0)
                        send_gap = $urandom_range(15, 1);
                end
                else
                begin
                    sample_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                got_segment.seg_start = start_sample;
                got_segment.seg_end = end_sample;
                got_segment.seg_energy = closing_energy;
                if (expected_segments.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected word start %0d end %0d energy %0d", $time,
                             start_sample, end_sample, closing_energy);
                end
                else
                begin
                    want_segment = expected_segments.pop_front();
                    if (got_segment !== want_segment)
                    begin
                        fail_count++;
                        $display("%0t: expected start %0d end %0d energy %0d, actual %0d %0d %0d",
                                 $time, want_segment.seg_start, want_segment.seg_end,
                                 want_segment.seg_energy, got_segment.seg_start,
                                 got_segment.seg_end, got_segment.seg_energy);
                    end
                end
            end
            if (stall_left > 0)
            begin
                result_stall <= 1'b1;
                stall_left = stall_left - 1;
            end
            else
            begin
                result_stall <= 1'b0;
                if (idle_on && $urandom_range(7, 0) == 0)
                    stall_left = $urandom_range(15, 1);
            end
        end
    end

    task automatic push_word(input logic signed [SAMPLE_FIELD_BITS-1:0] s, input logic fin);
        pcm_word_t w;
        w.pcm = s;
        w.last = fin;
        pending_words.insert(pending_words.size(), w);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        case (idx)
            CFG_ENERGY_THRESHOLD:
            begin
                cfg_data <= {16'($urandom), val[15:0]};
                cur_thr = val[15:0];
            end
            CFG_CHUNK_LENGTH:
            begin
                cfg_data <= {16'($urandom), val[15:0]};
                cur_len = val[15:0];
            end
            default:
            begin
                cfg_data <= val;
                cur_min = val;
            end
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // wait for all words taken and all segments seen, then let the block go idle
    task automatic settle();
        while (pending_words.size() != 0 || sample_valid || expected_segments.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic signed [SAMPLE_FIELD_BITS-1:0] make_pcm(input chunk_kind_t kind);
        int unsigned mag;
        bit          neg;
        case (kind)
            CHUNK_LOUD:  mag = (cur_thr < 16'd32768) ? $urandom_range(32768, cur_thr + 1) : 32768;
            CHUNK_QUIET: mag = $urandom_range(cur_thr, 0);
            default:     return 16'($urandom);
        endcase
        neg = (mag == 32768) || (mag != 0 && $urandom_range(1, 0) == 1);
        return neg ? 16'(-mag) : 16'(mag);
    endfunction

    task automatic queue_chunks(input int n_chunks);
        int unsigned span;
        int unsigned stop;
        int          roll;
        chunk_kind_t kind;
        span = (cur_len == 0) ? 1 : cur_len;
        for (int c = 0; c < n_chunks; c++)
        begin
            roll = $urandom_range(99, 0);
            kind = (roll < 45) ? CHUNK_LOUD : (roll < 90) ? CHUNK_QUIET : CHUNK_NOISE;
            stop = ($urandom_range(39, 0) == 0) ? $urandom_range(span, 1) : 0;
            for (int unsigned k = 1; k <= span; k++)
            begin
                push_word(make_pcm(kind), k == stop);
                if (k == stop)
                    break;
            end
        end
    endtask

    initial
    begin
        logic [15:0] thr;
        logic [15:0] len;
        logic [31:0] min_len;
        int unsigned span;
        int          roll;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings, short chunk closed by the last word
        push_word(16'sd32767, 1'b0);
        push_word(-16'sd32768, 1'b0);
        push_word(-16'sd1, 1'b0);
        push_word(16'sd0, 1'b1);
        settle();

        // zero length acts as one, zero threshold, zero minimum
        write_reg(CFG_ENERGY_THRESHOLD, 32'd0);
        write_reg(CFG_CHUNK_LENGTH, 32'd0);
        write_reg(CFG_MIN_SPEECH, 32'd0);
        push_word(16'sd32767, 1'b0);
        push_word(16'sd0, 1'b0);
        push_word(-16'sd32768, 1'b0);
        push_word(16'sd1, 1'b0);
        push_word(16'sd0, 1'b0);
        push_word(-16'sd1, 1'b0);
        push_word(16'sd0, 1'b1);
        settle();

        // top threshold: full-scale chunk equals the limit, not speech
        write_reg(CFG_ENERGY_THRESHOLD, 32'd32768);
        write_reg(CFG_CHUNK_LENGTH, 32'd4);
        write_reg(CFG_MIN_SPEECH, 32'hFFFF_FFFF);
        repeat (4) push_word(-16'sd32768, 1'b0);
        settle();

        // segment exactly at the minimum, then one too short
        write_reg(CFG_ENERGY_THRESHOLD, 32'd100);
        write_reg(CFG_CHUNK_LENGTH, 32'd2);
        write_reg(CFG_MIN_SPEECH, 32'd4);
        push_word(16'sd200, 1'b0);
        push_word(-16'sd200, 1'b0);
        push_word(16'sd32767, 1'b0);
        push_word(-16'sd5000, 1'b0);
        push_word(16'sd100, 1'b0);
        push_word(-16'sd100, 1'b0);
        push_word(16'sd300, 1'b0);
        push_word(16'sd300, 1'b0);
        push_word(16'sd0, 1'b0);
        push_word(16'sd0, 1'b0);
        push_word(16'sd50, 1'b1);
        settle();

        for (int p = 0; p < 11; p++)
        begin
            idle_on = (p < 9);
            roll = $urandom_range(9, 0);
            thr = (roll == 0) ? 16'd0 : (roll == 1) ? 16'd32768 :
                  (roll < 5) ? 16'($urandom_range(32768, 0)) : 16'($urandom_range(3000, 20));
            roll = $urandom_range(9, 0);
            len = (p == 3) ? 16'd65535 : (roll == 0) ? 16'd0 : (roll == 1) ? 16'd16 :
                  16'($urandom_range(6, 1));
            span = (len == 0) ? 1 : len;
            roll = $urandom_range(9, 0);
            min_len = (roll == 0) ? 32'd0 : (roll == 1) ? 32'hFFFF_FFFF :
                      $urandom_range(4 * span, 0);
            write_reg(CFG_MIN_SPEECH, min_len);
            write_reg(CFG_ENERGY_THRESHOLD, {16'd0, thr});
            write_reg(CFG_CHUNK_LENGTH, {16'd0, len});
            if (p == 3)
            begin
                for (int k = 0; k < 40; k++)
                    push_word(make_pcm(CHUNK_NOISE), k == 39);
            end
            else
            begin
                queue_chunks(75 / span);
            end
            settle();
        end

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
